>>> rtl/windowed_event_logic_gate_top_assert.svh
// assertion macros for the windowed event logic gate
`ifndef WINDOWED_EVENT_LOGIC_GATE_TOP_ASSERT_SVH
`define WINDOWED_EVENT_LOGIC_GATE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked at every rising edge out of reset
`define WEG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
// next-cycle implication, checked at every rising edge out of reset
`define WEG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define WEG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WEG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/weg_pkg.sv
`default_nettype none

package weg_pkg;

    // sizing
    localparam int OUTPUT_LINES = 8;
    localparam int TIMER_BITS   = 16;
    localparam int WINDOW_BITS  = 16;
    localparam int PULSE_BITS   = 16;
    localparam int LINE_BITS    = 3;
    localparam int TTL_BITS     = 8;
    localparam int MATCH_BITS   = 41;
    localparam int CFG_DATA_W   = 41;
    localparam int CFG_IDX_W    = 3;
    localparam int CMP_W        = (TIMER_BITS > WINDOW_BITS) ? TIMER_BITS : WINDOW_BITS;

    // match word layout
    localparam int MATCH_EN_BIT = 40;

    // register reset values
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(100);
    localparam logic [PULSE_BITS-1:0]  PULSE_RESET  = PULSE_BITS'(2);

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // gate modes
    typedef enum logic [1:0] {
        OP_AND   = 2'd0,
        OP_OR    = 2'd1,
        OP_XOR   = 2'd2,
        OP_DELAY = 2'd3
    } op_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOGIC_OP     = 3'd0,
        CFG_GATE_A       = 3'd1,
        CFG_GATE_B       = 3'd2,
        CFG_WINDOW_TICKS = 3'd3,
        CFG_PULSE_TICKS  = 3'd4,
        CFG_OUTPUT_LINE  = 3'd5,
        CFG_MATCH_A      = 3'd6,
        CFG_MATCH_B      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] source_node;
        logic [15:0] source_index;
        logic [7:0]  source_channel;
        logic        level;
    } in_item_t;

    typedef struct packed {
        logic                fire;
        logic [TTL_BITS-1:0] ttl_byte;
        logic                flag_a;
        logic                flag_b;
    } out_item_t;

    // identity compare against one enabled match word
    function automatic logic id_match(input logic [MATCH_BITS-1:0] m, input in_item_t it);
        id_match = m[MATCH_EN_BIT] &&
                   (m[39:24] == it.source_node) &&
                   (m[23:8] == it.source_index) &&
                   (m[7:0] == it.source_channel);
    endfunction

endpackage

`default_nettype wire

>>> rtl/windowed_event_logic_gate_top.sv
`default_nettype none
`include "windowed_event_logic_gate_top_assert.svh"

// Windowed two-input event logic gate. Event beats (kind 1) latch the A or B
// flag when their node/index/channel identity matches an enabled match
// register and the level is high, and may restart the elapsed-tick counter
// depending on gate_a/gate_b. Tick beats (kind 0) advance the saturating
// counter, count down the output pulse and evaluate the AND, OR, XOR or
// DELAY mode; a fire loads the pulse length and drives bit output_line of
// ttl_byte while the pulse lasts. Every input beat gives exactly one result
// beat. The block takes one beat per clock unless out_ready stalls the result
// register; a result passes the input register, then the result register,
// and the flag, counter and pulse updates are combinational between them.
// Configuration writes land immediately and are meant for idle periods.
module windowed_event_logic_gate_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [weg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [weg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire weg_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output weg_pkg::out_item_t                 out_data
);
    import weg_pkg::*;

    // configuration registers
    op_t                    logic_op_reg;
    logic                   gate_a_reg;
    logic                   gate_b_reg;
    logic [WINDOW_BITS-1:0] window_ticks_reg;
    logic [PULSE_BITS-1:0]  pulse_ticks_reg;
    logic [LINE_BITS-1:0]   output_line_reg;
    logic [MATCH_BITS-1:0]  match_a_reg;
    logic [MATCH_BITS-1:0]  match_b_reg;

    // pipeline registers
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    // gate state
    logic                  latched_a_reg, latched_a_next;
    logic                  latched_b_reg, latched_b_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [PULSE_BITS-1:0] pulse_left_reg, pulse_left_next;

    logic      out_free;
    logic      s1_adv;
    logic      hit_a, hit_b, nogate, restart;
    logic      fire_c;
    logic      in_win, past_win;
    out_item_t result_c;

    // handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logic_op_reg     <= OP_AND;
            gate_a_reg       <= 1'b0;
            gate_b_reg       <= 1'b0;
            window_ticks_reg <= WINDOW_RESET;
            pulse_ticks_reg  <= PULSE_RESET;
            output_line_reg  <= '0;
            match_a_reg      <= '0;
            match_b_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOGIC_OP:     logic_op_reg     <= op_t'(cfg_data[1:0]);
                CFG_GATE_A:       gate_a_reg       <= cfg_data[0];
                CFG_GATE_B:       gate_b_reg       <= cfg_data[0];
                CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data[WINDOW_BITS-1:0];
                CFG_PULSE_TICKS:  pulse_ticks_reg  <= cfg_data[PULSE_BITS-1:0];
                CFG_OUTPUT_LINE:  output_line_reg  <= cfg_data[LINE_BITS-1:0];
                CFG_MATCH_A:      match_a_reg      <= cfg_data[MATCH_BITS-1:0];
                CFG_MATCH_B:      match_b_reg      <= cfg_data[MATCH_BITS-1:0];
                default:          logic_op_reg     <= logic_op_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
    end

    // identity match
    assign hit_a   = s1_item_reg.level && id_match(match_a_reg, s1_item_reg);
    assign hit_b   = s1_item_reg.level && id_match(match_b_reg, s1_item_reg);
    assign nogate  = !gate_a_reg && !gate_b_reg;
    assign restart = (hit_a && (gate_a_reg || nogate)) || (hit_b && (gate_b_reg || nogate));

    // flag, counter and pulse update for one beat
    always_comb
    begin
        latched_a_next  = latched_a_reg;
        latched_b_next  = latched_b_reg;
        elapsed_next    = elapsed_reg;
        pulse_left_next = pulse_left_reg;
        fire_c          = 1'b0;
        in_win          = 1'b0;
        past_win        = 1'b0;
        if (s1_item_reg.kind == KIND_EVENT)
        begin
            if (hit_a)
            begin
                latched_a_next = 1'b1;
            end
            if (hit_b)
            begin
                latched_b_next = 1'b1;
            end
            if (restart)
            begin
                elapsed_next = '0;
            end
        end
        else
        begin
            // saturating tick count and pulse countdown
            if (elapsed_reg != '1)
            begin
                elapsed_next = elapsed_reg + TIMER_BITS'(1);
            end
            if (pulse_left_reg != '0)
            begin
                pulse_left_next = pulse_left_reg - PULSE_BITS'(1);
            end
            in_win   = CMP_W'(elapsed_next) < CMP_W'(window_ticks_reg);
            past_win = CMP_W'(elapsed_next) > CMP_W'(window_ticks_reg);
            // mode evaluation
            case (logic_op_reg)
                OP_AND:
                begin
                    if (in_win)
                    begin
                        if (latched_a_reg && latched_b_reg)
                        begin
                            fire_c = 1'b1;
                            if (gate_a_reg == gate_b_reg)
                            begin
                                latched_a_next = 1'b0;
                                latched_b_next = 1'b0;
                            end
                            else if (!gate_a_reg)
                            begin
                                latched_a_next = 1'b0;
                            end
                            else
                            begin
                                latched_b_next = 1'b0;
                            end
                        end
                        elapsed_next = '0;
                    end
                    else
                    begin
                        latched_a_next = 1'b0;
                        latched_b_next = 1'b0;
                    end
                end
                OP_OR:
                begin
                    if (past_win)
                    begin
                        fire_c         = latched_a_reg || latched_b_reg;
                        latched_a_next = 1'b0;
                        latched_b_next = 1'b0;
                        elapsed_next   = '0;
                    end
                end
                OP_XOR:
                begin
                    if (past_win)
                    begin
                        fire_c         = latched_a_reg != latched_b_reg;
                        latched_a_next = 1'b0;
                        latched_b_next = 1'b0;
                        elapsed_next   = '0;
                    end
                end
                default:
                begin
                    if (past_win)
                    begin
                        fire_c         = latched_a_reg;
                        latched_a_next = 1'b0;
                        elapsed_next   = '0;
                    end
                end
            endcase
            if (fire_c)
            begin
                pulse_left_next = pulse_ticks_reg;
            end
        end
    end

    // result assembly
    always_comb
    begin
        result_c.fire     = fire_c;
        result_c.ttl_byte = '0;
        if ((pulse_left_next != '0) &&
            ((LINE_BITS + 1)'(output_line_reg) < (LINE_BITS + 1)'(OUTPUT_LINES)))
        begin
            result_c.ttl_byte = TTL_BITS'(1) << output_line_reg;
        end
        result_c.flag_a = latched_a_next;
        result_c.flag_b = latched_b_next;
    end

    // gate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_a_reg  <= 1'b0;
            latched_b_reg  <= 1'b0;
            elapsed_reg    <= '0;
            pulse_left_reg <= '0;
        end
        else if (s1_adv)
        begin
            latched_a_reg  <= latched_a_next;
            latched_b_reg  <= latched_b_next;
            elapsed_reg    <= elapsed_next;
            pulse_left_reg <= pulse_left_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_item_reg <= result_c;
        end
    end

    // event beats never fire
    `WEG_ASSERT_NEXT(a_event_no_fire, clk, rst_n, s1_adv && (s1_item_reg.kind == KIND_EVENT), !out_item_reg.fire)
    // a fire loads the configured pulse length
    `WEG_ASSERT_NEXT(a_fire_loads_pulse, clk, rst_n, s1_adv && fire_c, pulse_left_reg == $past(pulse_ticks_reg))
    // gate state only moves when a beat is processed
    `WEG_ASSERT_NEXT(a_state_holds, clk, rst_n, !s1_adv, $stable(elapsed_reg) && $stable(latched_a_reg) && $stable(latched_b_reg))
    // shown flags track the stored flags while the result is held
    `WEG_ASSERT_IMPLY(a_flags_track, clk, rst_n, out_valid_reg, (out_item_reg.flag_a == latched_a_reg) && (out_item_reg.flag_b == latched_b_reg))

endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import weg_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [39:0] ID_ONES = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] ID_ZERO = 40'h00_0000_0000;

    // one line of the directed plan: a register write or a beat
    typedef struct packed {
        logic                  is_write;
        cfg_idx_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t              beat;
        logic                  typed;
        out_item_t             want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;

    // gate model: register copies
    op_t               cfg_op;
    logic              cfg_gate_a;
    logic              cfg_gate_b;
    logic [15:0]       cfg_window;
    logic [15:0]       cfg_pulse;
    logic [2:0]        cfg_line;
    logic [MATCH_BITS-1:0] cfg_match_a;
    logic [MATCH_BITS-1:0] cfg_match_b;

    // gate model: state
    logic              flag_a;
    logic              flag_b;
    logic [15:0]       elapsed;
    logic [15:0]       pulse_left;

    out_item_t         pending_gate_out[$];
    plan_row_t         plan_rows[$];

    int                send_idle_pct;
    int                recv_idle_pct;
    int                fail_count;
    int                cycle_count;
    int                beat_count;
    int                event_count;
    int                fire_count;
    int                checked_count;
    int                write_count;

    windowed_event_logic_gate_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // identity compare: enable bit plus node, index and channel
    function automatic logic identity_hit(input logic [MATCH_BITS-1:0] m, input in_item_t b);
        return m[MATCH_BITS-1] &&
               (m[39:0] == {b.source_node, b.source_index, b.source_channel});
    endfunction

    // advance the gate by one beat and return the result it gives
    function automatic out_item_t evaluate_gate(input in_item_t b);
        logic      no_gate;
        logic      fire;
        out_item_t r;
        fire = 1'b0;
        if (b.kind == KIND_EVENT)
        begin
            no_gate = !cfg_gate_a && !cfg_gate_b;
            if (b.level && identity_hit(cfg_match_a, b))
            begin
                flag_a = 1'b1;
                if (cfg_gate_a || no_gate)
                    elapsed = '0;
            end
            if (b.level && identity_hit(cfg_match_b, b))
            begin
                flag_b = 1'b1;
                if (cfg_gate_b || no_gate)
                    elapsed = '0;
            end
        end
        else
        begin
            if (elapsed != 16'hFFFF)
                elapsed = elapsed + 16'd1;
            if (pulse_left != '0)
                pulse_left = pulse_left - 16'd1;
            case (cfg_op)
                OP_AND:
                begin
                    if (elapsed < cfg_window)
                    begin
                        if (flag_a && flag_b)
                        begin
                            fire = 1'b1;
                            if (cfg_gate_a == cfg_gate_b)
                            begin
                                flag_a = 1'b0;
                                flag_b = 1'b0;
                            end
                            else if (!cfg_gate_a)
                                flag_a = 1'b0;
                            else
                                flag_b = 1'b0;
                        end
                        elapsed = '0;
                    end
                    else
                    begin
                        flag_a = 1'b0;
                        flag_b = 1'b0;
                    end
                end
                OP_OR:
                begin
                    if (elapsed > cfg_window)
                    begin
                        fire = flag_a || flag_b;
                        flag_a = 1'b0;
                        flag_b = 1'b0;
                        elapsed = '0;
                    end
                end
                OP_XOR:
                begin
                    if (elapsed > cfg_window)
                    begin
                        fire = flag_a ^ flag_b;
                        flag_a = 1'b0;
                        flag_b = 1'b0;
                        elapsed = '0;
                    end
                end
                default:
                begin
                    if (elapsed > cfg_window)
                    begin
                        fire = flag_a;
                        flag_a = 1'b0;
                        elapsed = '0;
                    end
                end
            endcase
            if (fire)
                pulse_left = cfg_pulse;
        end
        r.fire     = fire;
        r.ttl_byte = (pulse_left != '0) ? (8'h01 << cfg_line) : 8'h00;
        r.flag_a   = flag_a;
        r.flag_b   = flag_b;
        return r;
    endfunction

    function automatic in_item_t event_beat(input logic [39:0] id, input logic lvl);
        in_item_t b;
        b.kind           = KIND_EVENT;
        b.source_node    = id[39:24];
        b.source_index   = id[23:8];
        b.source_channel = id[7:0];
        b.level          = lvl;
        return b;
    endfunction

    // identity and level are don't-care on ticks, so fill them at random
    function automatic in_item_t tick_beat();
        in_item_t b;
        b.kind           = KIND_TICK;
        b.source_node    = 16'($urandom_range(0, 65535));
        b.source_index   = 16'($urandom_range(0, 65535));
        b.source_channel = 8'($urandom_range(0, 255));
        b.level          = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    function automatic plan_row_t beat_row(input in_item_t b, input logic typed,
                                           input out_item_t want);
        plan_row_t r;
        r = '0;
        r.beat  = b;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // offer one beat, then log its expected result once it is taken
    task automatic send_beat(input in_item_t b, input logic typed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = evaluate_gate(b);
        pending_gate_out.push_back(typed ? want : predicted);
        beat_count++;
        if (b.kind == KIND_EVENT)
            event_count++;
        if (predicted.fire)
            fire_count++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_gate_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LOGIC_OP:     cfg_op      = op_t'(val[1:0]);
            CFG_GATE_A:       cfg_gate_a  = val[0];
            CFG_GATE_B:       cfg_gate_b  = val[0];
            CFG_WINDOW_TICKS: cfg_window  = val[15:0];
            CFG_PULSE_TICKS:  cfg_pulse   = val[15:0];
            CFG_OUTPUT_LINE:  cfg_line    = val[2:0];
            CFG_MATCH_A:      cfg_match_a = val;
            default:          cfg_match_b = val;
        endcase
        write_count++;
        @(posedge clk);
    endtask

    // new settings: mostly short windows and pulses so that fires are frequent
    task automatic randomize_regs();
        logic [63:0]           r64;
        logic [CFG_DATA_W-1:0] ma;
        logic [CFG_DATA_W-1:0] mb;
        logic [15:0]           win;
        logic [15:0]           pls;
        r64 = {$urandom, $urandom};
        ma  = {1'($urandom_range(0, 7) != 0), r64[39:0]};
        r64 = {$urandom, $urandom};
        mb  = ($urandom_range(0, 9) == 0) ? ma : {1'($urandom_range(0, 7) != 0), r64[39:0]};
        case ($urandom_range(0, 9))
            0:       win = 16'h0000;
            1:       win = 16'hFFFF;
            2:       win = 16'($urandom_range(0, 65535));
            default: win = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0:       pls = 16'h0000;
            1:       pls = 16'hFFFF;
            default: pls = 16'($urandom_range(1, 4));
        endcase
        write_reg(CFG_LOGIC_OP, CFG_DATA_W'($urandom_range(0, 3)));
        write_reg(CFG_GATE_A, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_GATE_B, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'(win));
        write_reg(CFG_PULSE_TICKS, CFG_DATA_W'(pls));
        write_reg(CFG_OUTPUT_LINE, CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(CFG_MATCH_A, ma);
        write_reg(CFG_MATCH_B, mb);
    endtask

    // a burst of ticks and matching events, with some near misses and noise
    task automatic random_segment(input int n);
        int          k;
        int          pick;
        logic [39:0] id;
        logic [63:0] r64;
        drain();
        randomize_regs();
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_beat(tick_beat(), 1'b0, '0);
            else if (pick < 70)
                send_beat(event_beat(cfg_match_a[39:0], $urandom_range(0, 9) != 0), 1'b0, '0);
            else if (pick < 88)
                send_beat(event_beat(cfg_match_b[39:0], $urandom_range(0, 9) != 0), 1'b0, '0);
            else if (pick < 94)
            begin
                id = ($urandom_range(0, 1) != 0) ? cfg_match_a[39:0] : cfg_match_b[39:0];
                id = id ^ (40'h1 << $urandom_range(0, 39));
                send_beat(event_beat(id, 1'b1), 1'b0, '0);
            end
            else
            begin
                r64 = {$urandom, $urandom};
                send_beat(event_beat(r64[39:0], 1'($urandom_range(0, 1))), 1'b0, '0);
            end
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result checker
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_gate_out.size() == 0)
            begin
                $error("result beat with no expected result pending");
                fail_count++;
            end
            else
            begin
                want = pending_gate_out.pop_front();
                checked_count++;
                if (out_data.fire !== want.fire)
                begin
                    $error("fire mismatch: expected %0d, got %0d", want.fire, out_data.fire);
                    fail_count++;
                end
                if (out_data.ttl_byte !== want.ttl_byte)
                begin
                    $error("ttl_byte mismatch: expected %h, got %h",
                           want.ttl_byte, out_data.ttl_byte);
                    fail_count++;
                end
                if (out_data.flag_a !== want.flag_a)
                begin
                    $error("flag_a mismatch: expected %0d, got %0d", want.flag_a, out_data.flag_a);
                    fail_count++;
                end
                if (out_data.flag_b !== want.flag_b)
                begin
                    $error("flag_b mismatch: expected %0d, got %0d", want.flag_b, out_data.flag_b);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_gate_out.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_LOGIC_OP;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        send_idle_pct = 12;
        recv_idle_pct = 76;
        beat_count    = 0;
        event_count   = 0;
        fire_count    = 0;
        write_count   = 0;

        // model state after reset
        cfg_op      = OP_AND;
        cfg_gate_a  = 1'b0;
        cfg_gate_b  = 1'b0;
        cfg_window  = WINDOW_RESET;
        cfg_pulse   = PULSE_RESET;
        cfg_line    = '0;
        cfg_match_a = '0;
        cfg_match_b = '0;
        flag_a      = 1'b0;
        flag_b      = 1'b0;
        elapsed     = '0;
        pulse_left  = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan; want is {fire, ttl_byte, flag_a, flag_b}
        // reset values: AND, both inputs disabled
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h00, 1'b0, 1'b0}));
        plan_rows.push_back(beat_row(event_beat(ID_ZERO, 1'b1), 1'b1, {1'b0, 8'h00, 1'b0, 1'b0}));
        // coincidence of A and B inside the window, pulse on the top line
        plan_rows.push_back(reg_row(CFG_MATCH_A, {1'b1, ID_ONES}));
        plan_rows.push_back(reg_row(CFG_MATCH_B, {1'b1, ID_ZERO}));
        plan_rows.push_back(reg_row(CFG_OUTPUT_LINE, CFG_DATA_W'(7)));
        plan_rows.push_back(beat_row(event_beat(ID_ONES, 1'b0), 1'b1, {1'b0, 8'h00, 1'b0, 1'b0}));
        plan_rows.push_back(beat_row(event_beat(ID_ONES, 1'b1), 1'b1, {1'b0, 8'h00, 1'b1, 1'b0}));
        plan_rows.push_back(beat_row(event_beat(ID_ZERO, 1'b1), 1'b1, {1'b0, 8'h00, 1'b1, 1'b1}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b1, 8'h80, 1'b0, 1'b0}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h80, 1'b0, 1'b0}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h00, 1'b0, 1'b0}));
        // one event hits both inputs; A gating keeps flag_a on a fire
        plan_rows.push_back(reg_row(CFG_MATCH_B, {1'b1, ID_ONES}));
        plan_rows.push_back(reg_row(CFG_GATE_A, CFG_DATA_W'(1)));
        plan_rows.push_back(beat_row(event_beat(ID_ONES, 1'b1), 1'b1, {1'b0, 8'h00, 1'b1, 1'b1}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b1, 8'h80, 1'b1, 1'b0}));
        // OR with zero window and zero-length pulse: fire but no line
        plan_rows.push_back(reg_row(CFG_PULSE_TICKS, CFG_DATA_W'(0)));
        plan_rows.push_back(reg_row(CFG_WINDOW_TICKS, CFG_DATA_W'(0)));
        plan_rows.push_back(reg_row(CFG_LOGIC_OP, CFG_DATA_W'(OP_OR)));
        plan_rows.push_back(reg_row(CFG_GATE_A, CFG_DATA_W'(0)));
        plan_rows.push_back(reg_row(CFG_GATE_B, CFG_DATA_W'(1)));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b1, 8'h00, 1'b0, 1'b0}));
        // XOR with the widest window never fires, then DELAY and XOR with a short one
        plan_rows.push_back(reg_row(CFG_LOGIC_OP, CFG_DATA_W'(OP_XOR)));
        plan_rows.push_back(reg_row(CFG_WINDOW_TICKS, CFG_DATA_W'(16'hFFFF)));
        plan_rows.push_back(reg_row(CFG_PULSE_TICKS, CFG_DATA_W'(16'hFFFF)));
        plan_rows.push_back(reg_row(CFG_OUTPUT_LINE, CFG_DATA_W'(3)));
        plan_rows.push_back(beat_row(event_beat(ID_ONES, 1'b1), 1'b1, {1'b0, 8'h00, 1'b1, 1'b1}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h00, 1'b1, 1'b1}));
        plan_rows.push_back(reg_row(CFG_LOGIC_OP, CFG_DATA_W'(OP_DELAY)));
        plan_rows.push_back(reg_row(CFG_WINDOW_TICKS, CFG_DATA_W'(1)));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b1, 8'h08, 1'b0, 1'b1}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h08, 1'b0, 1'b1}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h08, 1'b0, 1'b1}));
        plan_rows.push_back(reg_row(CFG_LOGIC_OP, CFG_DATA_W'(OP_XOR)));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h08, 1'b0, 1'b1}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b1, 8'h08, 1'b0, 1'b0}));
        // AND with a zero window: every tick is outside and clears the flags
        plan_rows.push_back(reg_row(CFG_LOGIC_OP, CFG_DATA_W'(OP_AND)));
        plan_rows.push_back(reg_row(CFG_WINDOW_TICKS, CFG_DATA_W'(0)));
        plan_rows.push_back(beat_row(event_beat(ID_ONES, 1'b1), 1'b1, {1'b0, 8'h08, 1'b1, 1'b1}));
        plan_rows.push_back(beat_row(tick_beat(), 1'b1, {1'b0, 8'h08, 1'b0, 1'b0}));
        plan_rows.push_back(beat_row(event_beat({16'hFFFF, 16'hFFFF, 8'hFE}, 1'b1), 1'b1,
                                     {1'b0, 8'h08, 1'b0, 1'b0}));
        plan_rows.push_back(beat_row(event_beat(ID_ONES, 1'b1), 1'b0, '0));
        plan_rows.push_back(beat_row(tick_beat(), 1'b0, '0));

        foreach (plan_rows[n])
        begin
            if (plan_rows[n].is_write)
            begin
                drain();
                write_reg(plan_rows[n].reg_idx, plan_rows[n].reg_val);
            end
            else
                send_beat(plan_rows[n].beat, plan_rows[n].typed, plan_rows[n].want);
        end

        // random bursts under three stall patterns
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 76 : 0;
            recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 12 : 0;
            repeat (6) random_segment(36);
        end

        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d beats (%0d events, %0d fires) over %0d register writes",
                 beat_count, event_count, fire_count, write_count);
        $display("%0d results checked, all four modes under directed and random settings",
                 checked_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
